// ===== sv/psch_pkg.sv =====
// types and constants shared by the priority scheduler modules
// no dependencies
package psch_pkg;

  localparam int IDX_W  = 6;
  localparam int TIME_W = 21;
  localparam int SUM_W  = 25;

  typedef struct packed {
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  priority_req;
    logic        final_job;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        job_index;
    logic              idle;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic [SUM_W-1:0]  total_turnaround;
    logic [SUM_W-1:0]  total_waiting;
    logic              last_result;
  } out_item_t;

  // best candidate and earliest pending arrival, handed from cell to cell
  typedef struct packed {
    logic             found;
    logic [7:0]       prio;
    logic [15:0]      arr;
    logic [15:0]      burst;
    logic [IDX_W-1:0] idx;
    logic             seen;
    logic [15:0]      min_arr;
  } cand_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic              load;
    logic [IDX_W-1:0]  load_idx;
    logic              clear;
    logic              mark;
    logic [IDX_W-1:0]  mark_idx;
    logic [TIME_W-1:0] now;
  } cell_ctrl_t;

endpackage

// ===== sv/psch_cell.sv =====
// one job slot of the scheduler chain: holds a job and refines the candidate
// depends on psch_pkg
module psch_cell
  import psch_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  in_item_t   load_item,
  input  cand_t      cand_in,
  output cand_t      cand_out
);

  logic [15:0] arr_r;
  logic [15:0] burst_r;
  logic [7:0]  prio_r;
  logic        loaded_r;
  logic        done_r;
  cand_t       cand_r;
  cand_t       cand_nxt;
  logic        pending;
  logic        eligible;
  logic        better;

  always_ff @(posedge clk) begin
    if (ctrl.load && ctrl.load_idx == IDX_W'(IDX)) begin
      arr_r   <= load_item.arrival;
      burst_r <= load_item.burst;
      prio_r  <= load_item.priority_req;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= 1'b0;
      done_r   <= 1'b0;
    end else if (ctrl.clear) begin
      loaded_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      if (ctrl.load && ctrl.load_idx == IDX_W'(IDX)) begin
        loaded_r <= 1'b1;
      end
      if (ctrl.mark && ctrl.mark_idx == IDX_W'(IDX)) begin
        done_r <= 1'b1;
      end
    end
  end

  assign pending  = loaded_r && !done_r;
  assign eligible = pending && ({5'b0, arr_r} <= ctrl.now);
  // ties keep the upstream (lower index) candidate
  assign better = !cand_in.found || (prio_r < cand_in.prio) ||
                  ((prio_r == cand_in.prio) && (arr_r < cand_in.arr));

  always_comb begin
    cand_nxt = cand_in;
    if (eligible && better) begin
      cand_nxt.found = 1'b1;
      cand_nxt.prio  = prio_r;
      cand_nxt.arr   = arr_r;
      cand_nxt.burst = burst_r;
      cand_nxt.idx   = IDX_W'(IDX);
    end
    if (pending && (!cand_in.seen || arr_r < cand_in.min_arr)) begin
      cand_nxt.seen    = 1'b1;
      cand_nxt.min_arr = arr_r;
    end
  end

  always_ff @(posedge clk) begin
    cand_r <= cand_nxt;
  end

  assign cand_out = cand_r;

endmodule

// ===== sv/nonpreemptive_priority_scheduler.sv =====
// top level of the non-preemptive priority scheduler: sequencer and cell chain
// depends on psch_pkg and psch_cell
//
//  channel  direction  payload      handshake
//  in_      input      in_item_t    in_valid / in_stall
//  out_     output     out_item_t   out_valid / out_stall
//
// a job item is taken while the sequencer is loading; a non-final item yields no result
// for each result the candidate walks the cell chain, one cell per cycle, the
// sequencer updates time and sums, and the result is then held in the output
// register
// no item is taken from the final item until the last result is delivered
// reset clears the job slots, counters and the output valid
// a stalled result holds the sequencer in place
module nonpreemptive_priority_scheduler
  import psch_pkg::*;
#(
  parameter int MAX_JOBS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);

  typedef enum logic [2:0] {
    S_LOAD = 3'b001,
    S_SCAN = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  fin_r, fin_nxt;
  logic [CNT_W-1:0]  wait_r, wait_nxt;
  logic [5:0]        k_r, k_nxt;
  logic [TIME_W-1:0] now_r, now_nxt;
  logic [SUM_W-1:0]  sum_t_r, sum_t_nxt;
  logic [SUM_W-1:0]  sum_w_r, sum_w_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;
  cell_ctrl_t        ctrl;
  cand_t             cand_w [MAX_JOBS+1];
  cand_t             best;
  logic [TIME_W-1:0] run_end;
  logic [TIME_W-1:0] tat;
  logic [TIME_W-1:0] wt;
  logic              all_done;
  logic              in_acc;

  assign cand_w[0] = '0;

  for (genvar g = 0; g < MAX_JOBS; g++) begin : g_cell
    psch_cell #(.IDX(g)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctrl     (ctrl),
      .load_item(in_item),
      .cand_in  (cand_w[g]),
      .cand_out (cand_w[g+1])
    );
  end

  assign best     = cand_w[MAX_JOBS];
  assign run_end  = now_r + {5'b0, best.burst};
  assign tat      = run_end - {5'b0, best.arr};
  assign wt       = tat - {5'b0, best.burst};
  assign all_done = best.found && ((fin_r + 1'b1) == count_r);

  assign in_stall = (state_r != S_LOAD);
  assign in_acc   = in_valid && !in_stall;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    fin_nxt       = fin_r;
    wait_nxt      = wait_r;
    k_nxt         = k_r;
    now_nxt       = now_r;
    sum_t_nxt     = sum_t_r;
    sum_w_nxt     = sum_w_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    ctrl          = '0;
    ctrl.now      = now_r;
    ctrl.load_idx = IDX_W'(count_r);
    ctrl.mark_idx = best.idx;

    case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (count_r < CNT_W'(MAX_JOBS)) begin
            ctrl.load = 1'b1;
            count_nxt = count_r + 1'b1;
          end
          if (in_item.final_job) begin
            now_nxt   = '0;
            sum_t_nxt = '0;
            sum_w_nxt = '0;
            fin_nxt   = '0;
            k_nxt     = '0;
            wait_nxt  = '0;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (wait_r == CNT_W'(MAX_JOBS)) begin
          wait_nxt = '0;
          if (best.found) begin
            now_nxt   = run_end;
            sum_t_nxt = sum_t_r + {4'b0, tat};
            sum_w_nxt = sum_w_r + {4'b0, wt};
            fin_nxt   = fin_r + 1'b1;
            ctrl.mark = 1'b1;
          end else begin
            now_nxt = {5'b0, best.min_arr};
          end
          // only the first 32 segments get their own result
          if (k_r <= 6'd31) begin
            out_nxt.job_index  = best.found ? best.idx[3:0] : 4'd0;
            out_nxt.idle       = !best.found;
            out_nxt.end_time   = best.found ? run_end : {5'b0, best.min_arr};
            out_nxt.turnaround = best.found ? tat : '0;
            out_nxt.waiting    = best.found ? wt : '0;
            out_nxt.total_turnaround = '0;
            out_nxt.total_waiting    = '0;
            out_nxt.last_result      = 1'b0;
            k_nxt = k_r + 1'b1;
          end
          if (all_done) begin
            out_nxt.total_turnaround = sum_t_r + {4'b0, tat};
            out_nxt.total_waiting    = sum_w_r + {4'b0, wt};
            out_nxt.last_result      = 1'b1;
            out_valid_nxt            = 1'b1;
            state_nxt                = S_EMIT;
          end else if (k_r < 6'd31) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_EMIT;
          end
        end else begin
          wait_nxt = wait_r + 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_result) begin
            ctrl.clear = 1'b1;
            count_nxt  = '0;
            fin_nxt    = '0;
            state_nxt  = S_LOAD;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      count_r     <= '0;
      fin_r       <= '0;
      wait_r      <= '0;
      k_r         <= '0;
      now_r       <= '0;
      sum_t_r     <= '0;
      sum_w_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      fin_r       <= fin_nxt;
      wait_r      <= wait_nxt;
      k_r         <= k_nxt;
      now_r       <= now_nxt;
      sum_t_r     <= sum_t_nxt;
      sum_w_r     <= sum_w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == S_EMIT))
    else $error("result valid outside emit state");
  a_fin_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fin_r <= count_r)
    else $error("more jobs finished than loaded");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_JOBS))
    else $error("job count beyond slot count");
  a_last_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_item.last_result) |=> (state_r == S_LOAD))
    else $error("schedule did not return to loading");
`endif

endmodule

// ===== test/nonpreemptive_priority_scheduler_tb.sv =====
// testbench for the non-preemptive priority scheduler: loads job sets, predicts the schedule
// and compares every emitted segment; depends on psch_pkg and the scheduler rtl
module nonpreemptive_priority_scheduler_tb;
  import psch_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int JOBS = 16;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  logic [15:0] job_arr [JOBS];
  logic [15:0] job_burst [JOBS];
  logic [7:0]  job_prio [JOBS];
  int          jobs_held = 0;
  out_item_t   segment_queue[$];
  int          errors = 0;
  int          random_jobs = 0;
  bit          wide_gaps = 1'b1;

  nonpreemptive_priority_scheduler #(.MAX_JOBS(JOBS)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
  );

  always #6 clk = ~clk;

  // builds the expected segments for the stored set once the final job arrives
  task automatic schedule_jobs(input in_item_t job);
    logic [15:0] done;
    logic [20:0] now, tat, wt;
    logic [24:0] sum_tat, sum_wt;
    int          finished, pick, n;
    logic [15:0] next;
    bit          seen;
    out_item_t   seg;
    if (jobs_held < JOBS) begin
      job_arr[jobs_held] = job.arrival;
      job_burst[jobs_held] = job.burst;
      job_prio[jobs_held] = job.priority_req;
      jobs_held++;
    end
    if (!job.final_job) return;
    done = '0; now = '0; sum_tat = '0; sum_wt = '0; finished = 0; n = 0;
    while (finished < jobs_held) begin
      pick = -1;
      for (int i = 0; i < jobs_held; i++) begin
        if (done[i] || job_arr[i] > now) continue;
        if (pick < 0 || job_prio[i] < job_prio[pick] ||
            (job_prio[i] == job_prio[pick] && job_arr[i] < job_arr[pick]))
          pick = i;
      end
      seg = '0;
      if (pick >= 0) begin
        now = now + job_burst[pick];
        tat = now - job_arr[pick];
        wt = tat - job_burst[pick];
        sum_tat = sum_tat + tat;
        sum_wt = sum_wt + wt;
        done[pick] = 1'b1;
        finished++;
        seg.job_index = pick[3:0];
        seg.end_time = now;
        seg.turnaround = tat;
        seg.waiting = wt;
      end else begin
        seen = 1'b0; next = '0;
        for (int i = 0; i < jobs_held; i++)
          if (!done[i] && (!seen || job_arr[i] < next)) begin
            next = job_arr[i];
            seen = 1'b1;
          end
        now = 21'(next);
        seg.idle = 1'b1;
        seg.end_time = now;
      end
      if (n < 32) segment_queue.push_back(seg);
      n++;
    end
    seg = segment_queue.pop_back();
    seg.total_turnaround = sum_tat;
    seg.total_waiting = sum_wt;
    seg.last_result = 1'b1;
    segment_queue.push_back(seg);
    jobs_held = 0;
  endtask

  // valid stays high between back to back items and drops only for a gap
  task automatic send_job(input logic [15:0] arr, input logic [15:0] burst,
                          input logic [7:0] prio, input bit last);
    int gap;
    gap = wide_gaps ? $urandom_range(0, 11) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item <= '{arrival: arr, burst: burst, priority_req: prio, final_job: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    schedule_jobs('{arrival: arr, burst: burst, priority_req: prio, final_job: last});
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain_segments();
    stop_input();
    while (segment_queue.size() != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  // receiver stall, drawn per item
  initial begin
    int hold;
    forever begin
      @(negedge clk);
      hold = wide_gaps ? $urandom_range(0, 11) : 0;
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (segment_queue.size() == 0) begin
        $display("%0t unexpected segment %p", $time, out_item);
        errors++;
      end else begin
        out_item_t want;
        want = segment_queue.pop_front();
        if (out_item !== want) begin
          $display("%0t segment mismatch expected %p actual %p", $time, want, out_item);
          errors++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_job(16'hffff, 16'hffff, 8'hff, 1'b1);
    send_job(16'h0, 16'h0, 8'h0, 1'b1);
    send_job(16'h0, 16'hffff, 8'h80, 1'b0);
    send_job(16'hffff, 16'h0, 8'h7f, 1'b0);
    send_job(16'h5555, 16'haaaa, 8'h55, 1'b0);
    send_job(16'haaaa, 16'h5555, 8'haa, 1'b1);
    drain_segments();
  endtask

  // ties on priority and arrival, zero bursts, idle gaps
  task automatic test_ties_and_idle();
    send_job(16'd10, 16'd0, 8'd3, 1'b0);
    send_job(16'd10, 16'd5, 8'd3, 1'b0);
    send_job(16'd4, 16'd2, 8'd3, 1'b0);
    send_job(16'd100, 16'd1, 8'd0, 1'b1);
    drain_segments();
  endtask

  // more than the slots: the extra jobs, the final one too, are dropped, but the final one still starts the schedule
  task automatic test_overflow();
    for (int i = 0; i < JOBS + 3; i++)
      send_job(16'($urandom), 16'($urandom_range(0, 300)), 8'($urandom_range(0, 3)),
               i == JOBS + 2);
    drain_segments();
  endtask

  task automatic test_random_sets();
    int n;
    while (random_jobs < 370) begin
      n = ($urandom_range(0, 9) == 0) ? JOBS : $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 1))
          send_job(16'($urandom_range(0, 400)), 16'($urandom_range(0, 100)),
                   8'($urandom_range(0, 4)), i == n - 1);
        else
          send_job(16'($urandom), 16'($urandom), 8'($urandom), i == n - 1);
        random_jobs++;
      end
      if ($urandom_range(0, 7) == 0) begin
        stop_input();
        while (segment_queue.size() != 0) @(negedge clk);
        wide_gaps = ~wide_gaps;
      end
    end
    wide_gaps = 1'b1;
    drain_segments();
  endtask

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_extremes();
    test_ties_and_idle();
    test_overflow();
    test_random_sets();
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #30ms;
    $display("FAIL");
    $finish;
  end

endmodule
